>>> design/icmp_echo_request_frame_builder_core_defines.svh
// Assertion macros shared by the frame builder modules.
`ifndef ICMP_ECHO_REQUEST_FRAME_BUILDER_CORE_DEFINES_SVH
`define ICMP_ECHO_REQUEST_FRAME_BUILDER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post)
`define ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

>>> design/icmpfb_pkg.sv
// Shared types and constants of the ICMP echo request frame builder.
package icmpfb_pkg;

   // configuration register indexes
   localparam logic CsrSourceMac = 1'b0;
   localparam logic CsrSourceIp  = 1'b1;

   localparam int CsrDataWidth = 48;

   localparam int FrameLen   = 52;
   localparam int CountWidth = 6;
   localparam int PayloadOfs = 42;
   localparam int PayloadLen = 10;
   localparam int SumWidth   = 20;

   localparam logic [7:0] VerIhlNormal    = 8'h45;
   localparam logic [7:0] VerIhlMalformed = 8'h99;
   localparam logic [7:0] IpProtoIcmp     = 8'h01;
   localparam logic [7:0] IcmpEchoRequest = 8'h08;
   localparam logic [15:0] EtherTypeIpv4  = 16'h0800;
   localparam logic [15:0] IpTotalLen     = 16'd38;

   // fixed ASCII echo payload
   localparam logic [7:0] PayloadText [PayloadLen] = '{
      8'h54, 8'h45, 8'h53, 8'h54, 8'h5F, 8'h44, 8'h41, 8'h54, 8'h41, 8'h21
   };

   // constant part of the ICMP sum: type/code word plus payload words
   localparam logic [SumWidth-1:0] IcmpConstSum = SumWidth'(
      32'h0800 + 32'h5445 + 32'h5354 + 32'h5F44 + 32'h4154 + 32'h4121);

   // constant part of the IPv4 header sum: total length and protocol byte
   localparam logic [SumWidth-1:0] IpConstSum = SumWidth'(
      32'h0026 + 32'h0001);

   // one request with both header checksums resolved
   typedef struct packed {
      logic [7:0]  hop_limit;
      logic [31:0] dest_addr;
      logic        malformed;
      logic [15:0] echo_ident;
      logic [15:0] echo_seq;
      logic [15:0] ip_ck;
      logic [15:0] icmp_ck;
   } hdr_type;

   // request fields held in the input stage
   typedef struct packed {
      logic [7:0]  hop_limit;
      logic [31:0] dest_addr;
      logic        malformed;
      logic [15:0] echo_ident;
      logic [15:0] echo_seq;
   } req_type;

endpackage

>>> design/icmpfb_ifc.sv
// Request and response channel interfaces.
interface icmpfb_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  hop_limit;
   logic [31:0] dest_addr;
   logic        malformed;
   logic [15:0] echo_ident;
   logic [15:0] echo_seq;

   modport source (output valid, hop_limit, dest_addr, malformed, echo_ident, echo_seq,
                   input ready);
   modport sink (input valid, hop_limit, dest_addr, malformed, echo_ident, echo_seq,
                 output ready);
endinterface

interface icmpfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;

   modport source (output valid, frame_byte, last_byte, input ready);
   modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

>>> design/icmpfb_csr.sv
// Configuration registers: source MAC and source IPv4 address.
module icmpfb_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic                                 csr_index,
   input  logic [icmpfb_pkg::CsrDataWidth-1:0]  csr_wdata,
   output logic [47:0]                          source_mac,
   output logic [31:0]                          source_ip
);

   logic [47:0] mac_ff, mac_in;
   logic [31:0] ip_ff, ip_in;

   // register write decode
   always_comb begin
      mac_in = mac_ff;
      ip_in  = ip_ff;
      if (csr_we) begin
         case (csr_index)
            icmpfb_pkg::CsrSourceMac: mac_in = csr_wdata[47:0];
            icmpfb_pkg::CsrSourceIp:  ip_in  = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_ff <= '0;
         ip_ff  <= '0;
      end else begin
         mac_ff <= mac_in;
         ip_ff  <= ip_in;
      end
   end

   assign source_mac = mac_ff;
   assign source_ip  = ip_ff;

endmodule

>>> design/icmpfb_sum.sv
// Input register and checksum stage: raw sums, then fold and complement.
module icmpfb_sum (
   input  logic                 clock,
   input  logic                 reset,
   icmpfb_req_if.sink           req_chan,
   input  logic [31:0]          source_ip,
   output logic                 hdr_valid,
   input  logic                 hdr_ready,
   output icmpfb_pkg::hdr_type  hdr
);

   localparam int SW = icmpfb_pkg::SumWidth;

   logic                  v1_ff, v1_in;
   icmpfb_pkg::req_type   r1_ff;
   logic                  v2_ff, v2_in;
   icmpfb_pkg::req_type   r2_ff;
   logic [SW-1:0]         ip_sum_ff, ip_sum_in;
   logic [SW-1:0]         icmp_sum_ff, icmp_sum_in;
   logic                  adv1;
   logic                  take1;
   logic [7:0]            ver_byte;
   logic [16:0]           ip_t, icmp_t;
   logic [15:0]           ip_u, icmp_u;

   // stall chain
   assign adv1           = !v2_ff || hdr_ready;
   assign req_chan.ready = !v1_ff || adv1;
   assign take1          = req_chan.valid && req_chan.ready;
   assign v1_in          = req_chan.ready ? req_chan.valid : v1_ff;
   assign v2_in          = adv1 ? v1_ff : v2_ff;

   // raw ones'-complement sums of the 16-bit words
   assign ver_byte = r1_ff.malformed ? icmpfb_pkg::VerIhlMalformed
                                     : icmpfb_pkg::VerIhlNormal;
   assign ip_sum_in = icmpfb_pkg::IpConstSum
                    + {{(SW-16){1'b0}}, ver_byte, 8'h00}
                    + {{(SW-16){1'b0}}, r1_ff.hop_limit, 8'h00}
                    + {{(SW-16){1'b0}}, source_ip[31:16]}
                    + {{(SW-16){1'b0}}, source_ip[15:0]}
                    + {{(SW-16){1'b0}}, r1_ff.dest_addr[31:16]}
                    + {{(SW-16){1'b0}}, r1_ff.dest_addr[15:0]};
   assign icmp_sum_in = icmpfb_pkg::IcmpConstSum
                      + {{(SW-16){1'b0}}, r1_ff.echo_ident}
                      + {{(SW-16){1'b0}}, r1_ff.echo_seq};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take1) begin
         r1_ff.hop_limit  <= req_chan.hop_limit;
         r1_ff.dest_addr  <= req_chan.dest_addr;
         r1_ff.malformed  <= req_chan.malformed;
         r1_ff.echo_ident <= req_chan.echo_ident;
         r1_ff.echo_seq   <= req_chan.echo_seq;
      end
      if (adv1 && v1_ff) begin
         r2_ff       <= r1_ff;
         ip_sum_ff   <= ip_sum_in;
         icmp_sum_ff <= icmp_sum_in;
      end
   end

   // end-around carry fold and complement
   assign ip_t   = {1'b0, ip_sum_ff[15:0]} + {13'b0, ip_sum_ff[SW-1:16]};
   assign ip_u   = ip_t[15:0] + {15'b0, ip_t[16]};
   assign icmp_t = {1'b0, icmp_sum_ff[15:0]} + {13'b0, icmp_sum_ff[SW-1:16]};
   assign icmp_u = icmp_t[15:0] + {15'b0, icmp_t[16]};

   assign hdr_valid      = v2_ff;
   assign hdr.hop_limit  = r2_ff.hop_limit;
   assign hdr.dest_addr  = r2_ff.dest_addr;
   assign hdr.malformed  = r2_ff.malformed;
   assign hdr.echo_ident = r2_ff.echo_ident;
   assign hdr.echo_seq   = r2_ff.echo_seq;
   assign hdr.ip_ck      = ~ip_u;
   assign hdr.icmp_ck    = ~icmp_u;

endmodule

>>> design/icmpfb_ser.sv
// Frame serializer: byte counter, byte select and registered output.
`include "icmp_echo_request_frame_builder_core_defines.svh"
module icmpfb_ser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 hdr_valid,
   output logic                 hdr_ready,
   input  icmpfb_pkg::hdr_type  hdr,
   input  logic [47:0]          source_mac,
   input  logic [31:0]          source_ip,
   icmpfb_rsp_if.source         rsp_chan
);

   localparam int CW = icmpfb_pkg::CountWidth;
   localparam logic [CW-1:0] LastIdx = CW'(icmpfb_pkg::FrameLen - 1);

   logic                 busy_ff, busy_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   icmpfb_pkg::hdr_type  frm_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_byte_ff, rsp_byte_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 out_load;
   logic                 emit;
   logic                 take;
   logic [CW-1:0]        pofs;
   logic [3:0]           pidx;
   logic [7:0]           ver_byte;

   // handshake
   assign out_load  = !rsp_valid_ff || rsp_chan.ready;
   assign emit      = busy_ff && out_load;
   assign hdr_ready = !busy_ff || (emit && (cnt_ff == LastIdx));
   assign take      = hdr_valid && hdr_ready;

   // frame counter
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (emit) begin
         if (cnt_ff == LastIdx) begin
            busy_in = 1'b0;
            cnt_in  = '0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
      if (take) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end
   end

   // byte select
   assign pofs     = cnt_ff - CW'(icmpfb_pkg::PayloadOfs);
   assign pidx     = pofs[3:0];
   assign ver_byte = frm_ff.malformed ? icmpfb_pkg::VerIhlMalformed
                                      : icmpfb_pkg::VerIhlNormal;
   always_comb begin
      case (cnt_ff)
         6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5: rsp_byte_in = 8'hFF;
         6'd6:  rsp_byte_in = source_mac[47:40];
         6'd7:  rsp_byte_in = source_mac[39:32];
         6'd8:  rsp_byte_in = source_mac[31:24];
         6'd9:  rsp_byte_in = source_mac[23:16];
         6'd10: rsp_byte_in = source_mac[15:8];
         6'd11: rsp_byte_in = source_mac[7:0];
         6'd12: rsp_byte_in = icmpfb_pkg::EtherTypeIpv4[15:8];
         6'd13: rsp_byte_in = icmpfb_pkg::EtherTypeIpv4[7:0];
         6'd14: rsp_byte_in = ver_byte;
         6'd16: rsp_byte_in = icmpfb_pkg::IpTotalLen[15:8];
         6'd17: rsp_byte_in = icmpfb_pkg::IpTotalLen[7:0];
         6'd22: rsp_byte_in = frm_ff.hop_limit;
         6'd23: rsp_byte_in = icmpfb_pkg::IpProtoIcmp;
         6'd24: rsp_byte_in = frm_ff.ip_ck[15:8];
         6'd25: rsp_byte_in = frm_ff.ip_ck[7:0];
         6'd26: rsp_byte_in = source_ip[31:24];
         6'd27: rsp_byte_in = source_ip[23:16];
         6'd28: rsp_byte_in = source_ip[15:8];
         6'd29: rsp_byte_in = source_ip[7:0];
         6'd30: rsp_byte_in = frm_ff.dest_addr[31:24];
         6'd31: rsp_byte_in = frm_ff.dest_addr[23:16];
         6'd32: rsp_byte_in = frm_ff.dest_addr[15:8];
         6'd33: rsp_byte_in = frm_ff.dest_addr[7:0];
         6'd34: rsp_byte_in = icmpfb_pkg::IcmpEchoRequest;
         6'd36: rsp_byte_in = frm_ff.icmp_ck[15:8];
         6'd37: rsp_byte_in = frm_ff.icmp_ck[7:0];
         6'd38: rsp_byte_in = frm_ff.echo_ident[15:8];
         6'd39: rsp_byte_in = frm_ff.echo_ident[7:0];
         6'd40: rsp_byte_in = frm_ff.echo_seq[15:8];
         6'd41: rsp_byte_in = frm_ff.echo_seq[7:0];
         6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47, 6'd48, 6'd49, 6'd50, 6'd51:
            rsp_byte_in = icmpfb_pkg::PayloadText[pidx];
         // zero fields: TOS, identification, flags, ICMP code
         default: rsp_byte_in = 8'h00;
      endcase
   end

   assign rsp_last_in  = (cnt_ff == LastIdx);
   assign rsp_valid_in = out_load ? busy_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         frm_ff <= hdr;
      end
      if (emit) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.frame_byte = rsp_byte_ff;
   assign rsp_chan.last_byte  = rsp_last_ff;

   // checks
   `ASSERT_IMPLIES(a_cnt_range, clock, reset, busy_ff, cnt_ff <= LastIdx)
   `ASSERT_NEXT(a_frame_end, clock, reset, emit && (cnt_ff == LastIdx) && !take, !busy_ff)
   `ASSERT_NEXT(a_first_byte, clock, reset, emit && (cnt_ff == '0), rsp_byte_ff == 8'hFF && !rsp_last_ff)
   `ASSERT_IMPLIES(a_idle_count, clock, reset, !busy_ff, cnt_ff == '0)

endmodule

>>> design/icmp_echo_request_frame_builder_core.sv
// ICMP echo request frame builder: one request in, one 52-byte Ethernet
// frame out, one byte per accepted response transaction in wire order
// (broadcast destination, source MAC, IPv4 header with checksum, ICMP echo
// request with checksum and the fixed ten-byte ASCII payload). The frame is
// paced by the byte-wide output register and its frame counter; frames
// follow each other with no gap, and the next request is taken in while the
// current frame streams. After a request is accepted into the input register,
// its first byte passes through the checksum sum register, the frame register
// and the output register.
// Write source MAC (index 0) and source IP (index 1) only while no frame is
// pending.
module icmp_echo_request_frame_builder_core (
   input  logic                                clock,
   input  logic                                reset,
   icmpfb_req_if.sink                          req_chan,
   icmpfb_rsp_if.source                        rsp_chan,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [icmpfb_pkg::CsrDataWidth-1:0] csr_wdata
);

   logic [47:0]          source_mac;
   logic [31:0]          source_ip;
   logic                 hdr_valid;
   logic                 hdr_ready;
   icmpfb_pkg::hdr_type  hdr;

   icmpfb_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .source_mac (source_mac),
      .source_ip  (source_ip)
   );

   icmpfb_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .source_ip (source_ip),
      .hdr_valid (hdr_valid),
      .hdr_ready (hdr_ready),
      .hdr       (hdr)
   );

   icmpfb_ser u_ser (
      .clock      (clock),
      .reset      (reset),
      .hdr_valid  (hdr_valid),
      .hdr_ready  (hdr_ready),
      .hdr        (hdr),
      .source_mac (source_mac),
      .source_ip  (source_ip),
      .rsp_chan   (rsp_chan)
   );

endmodule

>>> test/icmpfb_frame_checker.sv
// Frame checker: watches both channels, predicts every frame and compares it byte by byte.
module icmpfb_frame_checker (
   input  logic                                clock,
   input  logic                                reset,
   icmpfb_req_if                               req_mon,
   icmpfb_rsp_if                               rsp_mon,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [icmpfb_pkg::CsrDataWidth-1:0] csr_wdata,
   output int                                  failures,
   output int                                  outstanding
);

   localparam int FrameBytes = 52;
   localparam int IpOfs      = 14;
   localparam int IcmpOfs    = 34;
   localparam int PayOfs     = 42;
   localparam int PayBytes   = 10;
   localparam int MaxReports = 200;

   localparam logic [7:0]  BroadcastByte = 8'hFF;
   localparam logic [15:0] TypeIpv4      = 16'h0800;
   localparam logic [7:0]  VersionIhl    = 8'h45;
   localparam logic [7:0]  VersionIhlBad = 8'h99;
   localparam logic [15:0] TotalLength   = 16'd38;
   localparam logic [7:0]  ProtoIcmp     = 8'h01;
   localparam logic [7:0]  EchoRequest   = 8'h08;
   // ASCII echo payload, first byte in the top bits
   localparam logic [8*PayBytes-1:0] EchoPayload = 80'h5445_5354_5F44_4154_4121;

   typedef logic [0:FrameBytes-1][7:0] frame_t;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } wire_byte_t;

   wire_byte_t  frame_byte_q [$];
   logic [47:0] src_mac;
   logic [31:0] src_ip;
   int          byte_pos;

   // ones' complement of the ones' complement sum of big-endian words
   function automatic logic [15:0] inet_checksum(frame_t f, int first, int count);
      logic [31:0] acc;
      acc = '0;
      for (int k = 0; k < count; k += 2)
         acc += {16'h0000, f[first + k], f[first + k + 1]};
      acc = (acc >> 16) + (acc & 32'h0000_FFFF);
      acc = acc + (acc >> 16);
      return ~acc[15:0];
   endfunction

   // whole frame for one request under the current source addresses
   function automatic frame_t build_frame(icmpfb_pkg::req_type r, logic [47:0] mac,
                                          logic [31:0] ip);
      frame_t f;
      f = '0;
      for (int k = 0; k < 6; k++) begin
         f[k]     = BroadcastByte;
         f[6 + k] = mac[47 - 8*k -: 8];
      end
      {f[12], f[13]} = TypeIpv4;

      f[IpOfs]                     = r.malformed ? VersionIhlBad : VersionIhl;
      {f[IpOfs + 2], f[IpOfs + 3]} = TotalLength;
      f[IpOfs + 8]                 = r.hop_limit;
      f[IpOfs + 9]                 = ProtoIcmp;
      for (int k = 0; k < 4; k++) begin
         f[IpOfs + 12 + k] = ip[31 - 8*k -: 8];
         f[IpOfs + 16 + k] = r.dest_addr[31 - 8*k -: 8];
      end
      {f[IpOfs + 10], f[IpOfs + 11]} = inet_checksum(f, IpOfs, 20);

      f[IcmpOfs]                       = EchoRequest;
      {f[IcmpOfs + 4], f[IcmpOfs + 5]} = r.echo_ident;
      {f[IcmpOfs + 6], f[IcmpOfs + 7]} = r.echo_seq;
      for (int k = 0; k < PayBytes; k++)
         f[PayOfs + k] = EchoPayload[8*PayBytes - 1 - 8*k -: 8];
      {f[IcmpOfs + 2], f[IcmpOfs + 3]} = inet_checksum(f, IcmpOfs, 8 + PayBytes);
      return f;
   endfunction

   // one line per mismatch; printing is capped, counting is not
   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] expected_val);
      failures++;
      if (failures <= MaxReports)
         $display("MISMATCH %s at frame byte %0d: got %02h, expected %02h",
                  what, byte_pos, got, expected_val);
   endtask

   initial failures = 0;

   // track configuration, queue predicted bytes, check response transactions
   always @(posedge clock) begin
      wire_byte_t want;
      frame_t     f;
      if (reset) begin
         frame_byte_q.delete();
         src_mac  = '0;
         src_ip   = '0;
         byte_pos = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == icmpfb_pkg::CsrSourceMac)
               src_mac = csr_wdata[47:0];
            else
               src_ip = csr_wdata[31:0];
         end

         if (req_mon.valid && req_mon.ready) begin
            f = build_frame({req_mon.hop_limit, req_mon.dest_addr, req_mon.malformed,
                             req_mon.echo_ident, req_mon.echo_seq}, src_mac, src_ip);
            for (int k = 0; k < FrameBytes; k++)
               frame_byte_q.push_back({f[k], k == FrameBytes - 1});
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (frame_byte_q.size() == 0) begin
               report_mismatch("byte with no frame pending", rsp_mon.frame_byte, 8'h00);
            end else begin
               want = frame_byte_q.pop_front();
               if (rsp_mon.frame_byte !== want.data)
                  report_mismatch("frame_byte", rsp_mon.frame_byte, want.data);
               if (rsp_mon.last_byte !== want.last)
                  report_mismatch("last_byte", 8'(rsp_mon.last_byte), 8'(want.last));
            end
            byte_pos = (byte_pos == FrameBytes - 1) ? 0 : byte_pos + 1;
         end
      end
      outstanding <= frame_byte_q.size();
   end

endmodule

>>> test/testbench.sv
// Testbench top: clock, reset, request stimulus, configuration writes and the verdict.
module testbench;

   logic                                clock;
   logic                                reset;
   logic                                csr_we;
   logic                                csr_index;
   logic [icmpfb_pkg::CsrDataWidth-1:0] csr_wdata;
   int                                  failures;
   int                                  outstanding;
   int                                  send_idle_pct;
   int                                  recv_idle_pct;

   icmpfb_req_if req_chan ();
   icmpfb_rsp_if rsp_chan ();

   icmp_echo_request_frame_builder_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   icmpfb_frame_checker frame_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // hard stop in case the block hangs
   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic icmpfb_pkg::req_type make_request(logic [7:0] hop, logic [31:0] dest,
                                                        logic bad, logic [15:0] ident,
                                                        logic [15:0] seq);
      icmpfb_pkg::req_type r;
      r.hop_limit  = hop;
      r.dest_addr  = dest;
      r.malformed  = bad;
      r.echo_ident = ident;
      r.echo_seq   = seq;
      return r;
   endfunction

   // random request, with address extremes now and then
   function automatic icmpfb_pkg::req_type random_request();
      logic [31:0] dest;
      case ($urandom_range(7))
         0:       dest = 32'h0000_0000;
         1:       dest = 32'hFFFF_FFFF;
         default: dest = $urandom;
      endcase
      return make_request(8'($urandom), dest, 1'($urandom), 16'($urandom), 16'($urandom));
   endfunction

   // one request transaction, with random idle cycles before it;
   // ready is sampled mid-cycle so it matches the value seen at the next edge
   task automatic send_request(icmpfb_pkg::req_type r);
      logic accepted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.hop_limit  <= r.hop_limit;
      req_chan.dest_addr  <= r.dest_addr;
      req_chan.malformed  <= r.malformed;
      req_chan.echo_ident <= r.echo_ident;
      req_chan.echo_seq   <= r.echo_seq;
      do begin
         @(negedge clock);
         accepted = req_chan.ready;
         @(posedge clock);
      end while (!accepted);
   endtask

   // hold off requests until every predicted byte has come out
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic index, logic [icmpfb_pkg::CsrDataWidth-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic set_source(logic [47:0] mac, logic [31:0] ip);
      write_reg(icmpfb_pkg::CsrSourceMac, mac);
      write_reg(icmpfb_pkg::CsrSourceIp, {16'h0000, ip});
      csr_we <= 1'b0;
   endtask

   task automatic send_random(int count);
      for (int n = 0; n < count; n++)
         send_request(random_request());
   endtask

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = icmpfb_pkg::CsrSourceMac;
      csr_wdata           = '0;
      req_chan.valid      = 1'b0;
      req_chan.hop_limit  = '0;
      req_chan.dest_addr  = '0;
      req_chan.malformed  = 1'b0;
      req_chan.echo_ident = '0;
      req_chan.echo_seq   = '0;
      rsp_chan.ready      = 1'b0;
      send_idle_pct       = 23;
      recv_idle_pct       = 88;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, malformed header, checksum corner values
      set_source(48'hFFFF_FFFF_FFFF, 32'h0000_0000);
      send_request(make_request(8'd0, 32'h0000_0000, 1'b0, 16'h0000, 16'h0000));
      send_request(make_request(8'd255, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF));
      send_request(make_request(8'd255, 32'h0000_0000, 1'b0, 16'hFFFF, 16'h0000));
      send_request(make_request(8'd0, 32'hFFFF_FFFF, 1'b1, 16'h0000, 16'hFFFF));
      send_request(make_request(8'd64, 32'h0A00_0001, 1'b1, 16'h1234, 16'h0001));
      send_request(make_request(8'd128, 32'h8000_0000, 1'b0, 16'h8000, 16'h8000));
      send_request(make_request(8'd1, 32'h0000_0001, 1'b1, 16'h0001, 16'h0001));
      // identifier plus sequence that drives the ICMP checksum to zero
      send_request(make_request(8'd64, 32'hC000_0201, 1'b0, 16'h6EAC, 16'h0000));
      send_request(make_request(8'd64, 32'hC000_0202, 1'b1, 16'h0000, 16'h6EAC));
      // end-around carry in the ICMP sum
      send_request(make_request(8'd32, 32'h1234_5678, 1'b0, 16'h6EAD, 16'hFFFF));
      send_request(make_request(8'd127, 32'h7FFF_FFFF, 1'b0, 16'h7FFF, 16'h7FFF));
      send_request(make_request(8'd170, 32'hAAAA_AAAA, 1'b1, 16'hAAAA, 16'h5555));
      send_request(make_request(8'd85, 32'h5555_5555, 1'b0, 16'h5555, 16'hAAAA));
      wait_drained();

      // random, slow sender and very slow receiver
      set_source(48'h0000_0000_0000, 32'hFFFF_FFFF);
      send_random(152);
      wait_drained();

      // random, roles swapped
      send_idle_pct = 88;
      recv_idle_pct = 23;
      set_source({16'($urandom), 32'($urandom)}, $urandom);
      send_random(152);
      wait_drained();

      // random, full rate on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_source({16'($urandom), 32'($urandom)}, $urandom);
      send_random(152);
      wait_drained();

      repeat (20) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
